FILE: sv/whsm_pkg.sv
`default_nettype none

package whsm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERN_DEFAULT = 64;
    localparam int MAX_TEXT_DEFAULT    = 65536;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character value is code minus ('a' - 1)
    localparam logic [8:0] CHAR_BIAS = 9'd96;

    // Hash polynomial base and the weight of the newest character
    localparam logic [31:0] HASH_BASE = 32'd10;
    localparam logic [31:0] HASH_ONE  = 32'd1;

    // Operation codes on the input channel
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // Request classes handed from front to back
    typedef enum logic [1:0] {
        KIND_PATTERN_START,
        KIND_PATTERN,
        KIND_TEXT_START,
        KIND_TEXT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] character;
    } cmd_t;

    // Character value as a 32-bit word, wrapping below 'a'
    function automatic logic [31:0] char_value(input logic [7:0] ch);
        logic [8:0] v;
        begin
            v = {1'b0, ch} - CHAR_BIAS;
            char_value = {{23{v[8]}}, v};
        end
    endfunction

    // Signed 9-bit character value, for the narrow multiplier
    function automatic logic signed [8:0] char_value9(input logic [7:0] ch);
        begin
            char_value9 = $signed({1'b0, ch} - CHAR_BIAS);
        end
    endfunction

    // Multiply by the hash base with two shifts and an add
    function automatic logic [31:0] mul_base(input logic [31:0] x);
        begin
            mul_base = (x << 3) + (x << 1);
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/whsm_ram.sv
`default_nettype none

module whsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/whsm_front.sv
`default_nettype none

module whsm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire logic           operation,
    input  wire logic           first,
    input  wire logic [7:0]     character,
    output whsm_pkg::cmd_t      cmd,
    output logic                cmd_valid,
    input  wire logic           cmd_pop
);

    localparam int PTR_W = (whsm_pkg::QUEUE_DEPTH > 1) ? $clog2(whsm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(whsm_pkg::QUEUE_DEPTH + 1);

    whsm_pkg::cmd_t   q_reg [whsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    whsm_pkg::cmd_t   cmd_new;

    // Classify the incoming request
    always_comb
    begin
        cmd_new.character = character;
        if (operation == whsm_pkg::OP_TEXT)
        begin
            cmd_new.kind = first ? whsm_pkg::KIND_TEXT_START : whsm_pkg::KIND_TEXT;
        end
        else
        begin
            cmd_new.kind = first ? whsm_pkg::KIND_PATTERN_START : whsm_pkg::KIND_PATTERN;
        end
    end

    // Stall only on a full queue
    assign item_stall = (count_reg == CNT_W'(whsm_pkg::QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign pop        = cmd_pop && cmd_valid;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_reg[rd_ptr_reg];

    // Advance queue pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(whsm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(whsm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queue entries, write on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

`default_nettype wire

FILE: sv/whsm_back.sv
`default_nettype none

module whsm_back #(
    parameter int MAX_PATTERN = whsm_pkg::MAX_PATTERN_DEFAULT,
    parameter int MAX_TEXT    = whsm_pkg::MAX_TEXT_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire whsm_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    output logic                result_valid,
    input  wire logic           result_stall,
    output logic                match,
    output logic [15:0]         match_start,
    output logic [15:0]         match_end,
    output logic                pattern_error
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [15:0] TEXT_LIMIT = 16'(MAX_TEXT - 1);

    // Matcher state
    logic [31:0]      pattern_hash_reg, pattern_hash_next;
    logic [LEN_W-1:0] pattern_length_reg, pattern_length_next;
    logic             pattern_over_reg, pattern_over_next;
    logic [31:0]      top_power_reg, top_power_next;
    logic [31:0]      window_hash_reg, window_hash_next;
    logic [LEN_W-1:0] window_fill_reg, window_fill_next;
    logic [15:0]      text_index_reg, text_index_next;
    logic [PTR_W-1:0] ring_pos_reg, ring_pos_next;

    // Read bypass for a window of one character
    logic             bypass_reg, bypass_next;
    logic [7:0]       bypass_data_reg;

    // Result register
    logic             result_valid_reg, result_valid_next;
    logic             match_reg, match_next;
    logic [15:0]      match_start_reg, match_start_next;
    logic [15:0]      match_end_reg, match_end_next;
    logic             pattern_error_reg, pattern_error_next;

    logic             exec;
    logic             is_start;
    logic [31:0]      val;
    logic [7:0]       old_char;
    logic [7:0]       ram_rdata;
    logic signed [40:0] old_prod;
    logic [31:0]      ph_b;
    logic [LEN_W-1:0] len_b;
    logic [31:0]      top_b;
    logic [31:0]      wh_b;
    logic [LEN_W-1:0] fill_b;
    logic             ram_we;
    logic [PTR_W-1:0] rd_addr;
    logic [LEN_W:0]   rd_sum;

    // Execute a request when the result register can take it
    assign exec     = cmd_valid && (!result_valid_reg || !result_stall);
    assign cmd_pop  = exec;
    assign is_start = (cmd.kind == whsm_pkg::KIND_PATTERN_START) ||
                      (cmd.kind == whsm_pkg::KIND_TEXT_START);
    assign val      = whsm_pkg::char_value(cmd.character);

    // Character leaving the window, weighted by the top power
    assign old_char = bypass_reg ? bypass_data_reg : ram_rdata;
    assign old_prod = whsm_pkg::char_value9(old_char) * $signed({1'b0, top_power_reg});

    always_comb
    begin
        pattern_hash_next   = pattern_hash_reg;
        pattern_length_next = pattern_length_reg;
        pattern_over_next   = pattern_over_reg;
        top_power_next      = top_power_reg;
        window_hash_next    = window_hash_reg;
        window_fill_next    = window_fill_reg;
        text_index_next     = text_index_reg;
        ring_pos_next       = ring_pos_reg;
        ram_we              = 1'b0;
        match_next          = match_reg;
        match_start_next    = match_start_reg;
        match_end_next      = match_end_reg;
        ph_b                = is_start ? '0 : pattern_hash_reg;
        len_b               = is_start ? '0 : pattern_length_reg;
        top_b               = is_start ? whsm_pkg::HASH_ONE : top_power_reg;
        wh_b                = is_start ? '0 : window_hash_reg;
        fill_b              = is_start ? '0 : window_fill_reg;

        if (exec)
        begin
            match_next       = 1'b0;
            match_start_next = '0;
            match_end_next   = '0;
            case (cmd.kind)
                whsm_pkg::KIND_PATTERN_START, whsm_pkg::KIND_PATTERN:
                begin
                    // Extend the pattern hash, drop characters past the limit
                    pattern_hash_next   = ph_b;
                    pattern_length_next = len_b;
                    pattern_over_next   = is_start ? 1'b0 : pattern_over_reg;
                    top_power_next      = top_b;
                    if (len_b == LEN_W'(MAX_PATTERN))
                    begin
                        pattern_over_next = 1'b1;
                    end
                    else
                    begin
                        if (len_b != '0)
                        begin
                            top_power_next = whsm_pkg::mul_base(top_b);
                        end
                        pattern_hash_next   = whsm_pkg::mul_base(ph_b) + val;
                        pattern_length_next = len_b + 1'b1;
                    end
                    // Empty the window
                    window_hash_next = '0;
                    window_fill_next = '0;
                end
                whsm_pkg::KIND_TEXT_START, whsm_pkg::KIND_TEXT:
                begin
                    // Restart or advance the saturating text index
                    if (is_start)
                    begin
                        text_index_next = '0;
                    end
                    else if (text_index_reg < TEXT_LIMIT)
                    begin
                        text_index_next = text_index_reg + 16'd1;
                    end
                    window_hash_next = wh_b;
                    window_fill_next = fill_b;
                    if (pattern_length_reg != '0)
                    begin
                        // Roll the window: remove the oldest once full, append the newest
                        if (fill_b >= pattern_length_reg)
                        begin
                            wh_b = wh_b - old_prod[31:0];
                        end
                        else
                        begin
                            fill_b = fill_b + 1'b1;
                        end
                        window_hash_next = whsm_pkg::mul_base(wh_b) + val;
                        window_fill_next = fill_b;
                        ram_we           = 1'b1;
                        ring_pos_next    = (ring_pos_reg == PTR_W'(MAX_PATTERN - 1)) ? '0
                                                                 : ring_pos_reg + 1'b1;
                        if (!pattern_over_reg && (fill_b == pattern_length_reg) &&
                            (window_hash_next == pattern_hash_reg))
                        begin
                            match_next       = 1'b1;
                            match_end_next   = text_index_next;
                            match_start_next = text_index_next - 16'(pattern_length_reg)
                                               + 16'd1;
                        end
                    end
                end
                default:
                begin
                    window_hash_next = window_hash_reg;
                end
            endcase
        end
    end

    // Error flag follows the pattern state after this request
    assign pattern_error_next = exec ? ((pattern_length_next == '0) || pattern_over_next)
                                     : pattern_error_reg;

    // Load the result register, drop it once taken
    always_comb
    begin
        if (exec)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // Address of the character that leaves with the next text request
    always_comb
    begin
        rd_sum = (LEN_W + 1)'(ring_pos_next) + (LEN_W + 1)'(MAX_PATTERN)
                 - (LEN_W + 1)'(pattern_length_next);
        if (rd_sum >= (LEN_W + 1)'(MAX_PATTERN))
        begin
            rd_addr = PTR_W'(rd_sum - (LEN_W + 1)'(MAX_PATTERN));
        end
        else
        begin
            rd_addr = PTR_W'(rd_sum);
        end
    end

    assign bypass_next = ram_we && (rd_addr == ring_pos_reg);

    whsm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_pos_reg),
        .wdata (cmd.character),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_hash_reg   <= '0;
            pattern_length_reg <= '0;
            pattern_over_reg   <= 1'b0;
            top_power_reg      <= whsm_pkg::HASH_ONE;
            window_hash_reg    <= '0;
            window_fill_reg    <= '0;
            text_index_reg     <= '0;
            ring_pos_reg       <= '0;
            bypass_reg         <= 1'b0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            pattern_hash_reg   <= pattern_hash_next;
            pattern_length_reg <= pattern_length_next;
            pattern_over_reg   <= pattern_over_next;
            top_power_reg      <= top_power_next;
            window_hash_reg    <= window_hash_next;
            window_fill_reg    <= window_fill_next;
            text_index_reg     <= text_index_next;
            ring_pos_reg       <= ring_pos_next;
            bypass_reg         <= bypass_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    // Hold payload of the result and the bypass byte
    always_ff @(posedge clk)
    begin
        bypass_data_reg   <= cmd.character;
        match_reg         <= match_next;
        match_start_reg   <= match_start_next;
        match_end_reg     <= match_end_next;
        pattern_error_reg <= pattern_error_next;
    end

    assign result_valid  = result_valid_reg;
    assign match         = match_reg;
    assign match_start   = match_start_reg;
    assign match_end     = match_end_reg;
    assign pattern_error = pattern_error_reg;

endmodule

`default_nettype wire

FILE: sv/window_hash_string_matcher_unit.sv
// A request is held in the front-end queue, then in the back-end result register until taken.
// Throughput: one request per cycle unless the result side stalls, set by the rolling hash
// update (one 9x32 multiply, a shift-add and a 32-bit compare) in the back end.
// Reset (asynchronous, active low) clears hashes, lengths, text index, queue and result valid flag;
// the character ring is not cleared, an entry is only read after it was written.
`default_nettype none

module window_hash_string_matcher_unit #(
    parameter int MAX_PATTERN = whsm_pkg::MAX_PATTERN_DEFAULT,
    parameter int MAX_TEXT    = whsm_pkg::MAX_TEXT_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        operation,
    input  wire logic        first,
    input  wire logic [7:0]  character,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             match,
    output logic [15:0]      match_start,
    output logic [15:0]      match_end,
    output logic             pattern_error
);

    whsm_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // Accept and classify requests into the queue
    whsm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .operation  (operation),
        .first      (first),
        .character  (character),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop)
    );

    // Update hashes and report matches
    whsm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .match         (match),
        .match_start   (match_start),
        .match_end     (match_end),
        .pattern_error (pattern_error)
    );

endmodule

`default_nettype wire

FILE: sv/whsm_checker.sv
`default_nettype none

module whsm_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic        item_stall,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic        match,
    input  wire logic [15:0] match_start,
    input  wire logic [15:0] match_end,
    input  wire logic        pattern_error
);

    logic [2:0] pending_reg, pending_next;
    logic       item_acc;
    logic       result_acc;

    assign item_acc   = item_valid && !item_stall;
    assign result_acc = result_valid && !result_stall;

    // Track requests accepted but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (item_acc && !result_acc)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (result_acc && !item_acc)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Every result answers an earlier request
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_acc |-> (pending_reg != 3'd0))
        else $error("result delivered with no outstanding request");

    // Queue plus result register bound the requests in flight
    a_bounded_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many requests in flight");

    // A bad pattern never matches
    a_no_match_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && match) |-> !pattern_error)
        else $error("match reported with pattern error");

    // Indexes are zero without a match
    a_zero_index_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !match) |-> ((match_start == 16'd0) && (match_end == 16'd0)))
        else $error("nonzero index without match");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(match) && $stable(match_start) &&
             $stable(match_end) && $stable(pattern_error)))
        else $error("stalled result changed");

endmodule

bind window_hash_string_matcher_unit whsm_checker u_whsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .match         (match),
    .match_start   (match_start),
    .match_end     (match_end),
    .pattern_error (pattern_error)
);

`default_nettype wire

FILE: test/tb_window_hash_string_matcher_unit.sv
`timescale 1ns / 1ps

module tb_window_hash_string_matcher_unit;

    localparam int PAT_MAX      = whsm_pkg::MAX_PATTERN_DEFAULT;
    localparam int TEXT_CAP     = (whsm_pkg::MAX_TEXT_DEFAULT - 1 > 65535) ? 65535
                                                                          : whsm_pkg::MAX_TEXT_DEFAULT - 1;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BUDGET = 42;

    typedef struct packed {
        logic       op;
        logic       first;
        logic [7:0] ch;
    } request_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] start_idx;
        logic [15:0] end_idx;
        logic        err;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        operation = 1'b0;
    logic        first = 1'b0;
    logic [7:0]  character = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        match;
    logic [15:0] match_start;
    logic [15:0] match_end;
    logic        pattern_error;

    // Request traffic and expected verdicts
    request_t pending_q[$];
    verdict_t verdict_expect_q[$];
    request_t drive_rq;
    verdict_t seen_verdict;
    verdict_t want_verdict;
    logic     item_taken = 1'b0;
    int       items_queued = 0;
    int       items_taken = 0;
    int       fault_count = 0;

    // Idling knobs for the current phase
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    logic     pressure_on = 1'b0;
    int       hold_count = 0;

    // Pattern buffer used to plant copies in the text
    logic [7:0] pat_buf [0:79];
    int         pat_buf_len = 0;

    // Matcher state as predicted
    logic [31:0] pat_hash = '0;
    logic [31:0] pow_top = whsm_pkg::HASH_ONE;
    logic [31:0] win_hash = '0;
    int unsigned pat_len = 0;
    int unsigned win_fill = 0;
    int unsigned ring_wr = 0;
    int unsigned txt_idx = 0;
    bit          pat_over = 1'b0;
    logic [7:0]  ring_chars [PAT_MAX];

    window_hash_string_matcher_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .first         (first),
        .character     (character),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .match         (match),
        .match_start   (match_start),
        .match_end     (match_end),
        .pattern_error (pattern_error)
    );

    always #5 clk = ~clk;

    // Character weight: code minus the bias, wrapping in 32 bits
    function automatic logic [31:0] weight_of(input logic [7:0] ch);
        return {24'd0, ch} - {23'd0, whsm_pkg::CHAR_BIAS};
    endfunction

    // Advance the predicted matcher by one request and queue its verdict
    function automatic void advance_matcher(input request_t rq);
        verdict_t    v;
        int unsigned m;
        int unsigned old;
        v = '0;
        if (rq.op == whsm_pkg::OP_PATTERN)
        begin
            if (rq.first)
            begin
                pat_hash = '0;
                pat_len  = 0;
                pat_over = 1'b0;
                pow_top  = whsm_pkg::HASH_ONE;
            end
            if (pat_len >= PAT_MAX)
            begin
                pat_over = 1'b1;
            end
            else
            begin
                if (pat_len > 0)
                    pow_top = pow_top * whsm_pkg::HASH_BASE;
                pat_hash = pat_hash * whsm_pkg::HASH_BASE + weight_of(rq.ch);
                pat_len++;
            end
            win_hash = '0;
            win_fill = 0;
        end
        else
        begin
            m = pat_len;
            if (rq.first)
            begin
                win_hash = '0;
                win_fill = 0;
                txt_idx  = 0;
            end
            else if (txt_idx < TEXT_CAP)
            begin
                txt_idx++;
            end
            if (m > 0)
            begin
                // drop the oldest character once the window is full
                if (win_fill >= m)
                begin
                    old = (ring_wr + PAT_MAX - m) % PAT_MAX;
                    win_hash = win_hash - weight_of(ring_chars[old]) * pow_top;
                end
                else
                begin
                    win_fill++;
                end
                win_hash = win_hash * whsm_pkg::HASH_BASE + weight_of(rq.ch);
                ring_chars[ring_wr] = rq.ch;
                ring_wr = (ring_wr + 1) % PAT_MAX;
                if (!pat_over && win_fill == m && win_hash == pat_hash)
                begin
                    v.hit       = 1'b1;
                    v.end_idx   = 16'(txt_idx);
                    v.start_idx = 16'(txt_idx - m + 1);
                end
            end
        end
        v.err = (pat_len == 0) || pat_over;
        verdict_expect_q.push_back(v);
    endfunction

    task automatic push_request(input logic op, input logic fst, input logic [7:0] ch);
        request_t rq;
        rq.op    = op;
        rq.first = fst;
        rq.ch    = ch;
        pending_q.push_back(rq);
        items_queued++;
    endtask

    // Queue a fresh pattern drawn from the first span letters
    task automatic send_pattern(input int len, input int span);
        for (int i = 0; i < len; i++)
        begin
            pat_buf[i] = 8'd97 + 8'($urandom_range(span - 1));
            push_request(whsm_pkg::OP_PATTERN, i == 0, pat_buf[i]);
        end
        pat_buf_len = len;
    endtask

    // Queue text mixing random letters with planted pattern copies
    task automatic send_text(input int len, input int plen, input int span, input bit fresh);
        int pos;
        pos = 0;
        while (pos < len)
        begin
            if (plen > 0 && $urandom_range(3) == 0)
            begin
                for (int k = 0; k < plen; k++)
                begin
                    push_request(whsm_pkg::OP_TEXT, fresh && pos == 0, pat_buf[k]);
                    pos++;
                end
            end
            else
            begin
                push_request(whsm_pkg::OP_TEXT, fresh && pos == 0,
                             8'd97 + 8'($urandom_range(span - 1)));
                pos++;
            end
        end
    endtask

    // Mostly well-formed pattern/text runs, some continuations and raw noise
    task automatic random_traffic(input int budget);
        int stop_at;
        int kind;
        int span;
        int plen;
        int n;
        stop_at = items_queued + budget;
        while (items_queued < stop_at)
        begin
            kind = $urandom_range(99);
            span = ($urandom_range(3) == 0) ? 26 : $urandom_range(2, 3);
            if (kind < 70)
            begin
                plen = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
                send_pattern(plen, span);
                send_text($urandom_range(4, 20) + plen, plen, span, $urandom_range(4) != 0);
            end
            else if (kind < 85)
            begin
                send_text($urandom_range(3, 15), pat_buf_len, span, 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    push_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Wait until every request is taken and every verdict checked
    task automatic drain();
        while (items_taken != items_queued || verdict_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Offer the next request once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_rq = pending_q.pop_front();
                item_valid <= 1'b1;
                operation  <= drive_rq.op;
                first      <= drive_rq.first;
                character  <= drive_rq.ch;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted request
    always @(posedge clk)
    begin
        item_taken <= rst_n && item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
        begin
            advance_matcher({operation, first, character});
            items_taken <= items_taken + 1;
        end
    end

    // Stall the result side at random, or hold off for a long stretch under pressure
    always @(negedge clk)
    begin
        if (pressure_on && hold_count < HOLD_CYCLES)
        begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check each accepted result against the oldest expected verdict
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen_verdict = {match, match_start, match_end, pattern_error};
            if (verdict_expect_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: match %0b start %0d end %0d err %0b",
                             match, match_start, match_end, pattern_error);
            end
            else
            begin
                want_verdict = verdict_expect_q.pop_front();
                if (seen_verdict !== want_verdict)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch (exp/got): match %0b/%0b start %0d/%0d end %0d/%0d err %0b/%0b",
                                 want_verdict.hit, seen_verdict.hit,
                                 want_verdict.start_idx, seen_verdict.start_idx,
                                 want_verdict.end_idx, seen_verdict.end_idx,
                                 want_verdict.err, seen_verdict.err);
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: text with no pattern, a hash collision, byte extremes
        set_idling(0, 0);
        push_request(whsm_pkg::OP_TEXT, 1'b0, 8'h00);
        push_request(whsm_pkg::OP_TEXT, 1'b1, 8'hff);
        push_request(whsm_pkg::OP_PATTERN, 1'b1, "b");
        push_request(whsm_pkg::OP_PATTERN, 1'b0, "a");
        push_request(whsm_pkg::OP_TEXT, 1'b1, "a");
        push_request(whsm_pkg::OP_TEXT, 1'b0, "k");
        push_request(whsm_pkg::OP_TEXT, 1'b0, "b");
        push_request(whsm_pkg::OP_TEXT, 1'b0, "a");
        push_request(whsm_pkg::OP_PATTERN, 1'b1, 8'h00);
        push_request(whsm_pkg::OP_TEXT, 1'b1, 8'h00);
        push_request(whsm_pkg::OP_PATTERN, 1'b1, 8'hff);
        push_request(whsm_pkg::OP_TEXT, 1'b0, 8'hff);
        // extend the pattern mid-text, then continue the text without a start flag
        push_request(whsm_pkg::OP_PATTERN, 1'b0, "c");
        push_request(whsm_pkg::OP_TEXT, 1'b0, 8'hff);
        push_request(whsm_pkg::OP_TEXT, 1'b0, "c");
        drain();

        // Random phases with different idling
        set_idling(0, 0);
        random_traffic(PHASE_BUDGET);
        drain();
        set_idling(78, 0);
        random_traffic(PHASE_BUDGET);
        drain();
        set_idling(0, 78);
        random_traffic(PHASE_BUDGET);
        drain();
        set_idling(33, 33);
        random_traffic(PHASE_BUDGET);
        drain();

        // Back-pressure: full-length pattern found in text, then an overlong one
        set_idling(0, 0);
        pressure_on = 1'b1;
        send_pattern(PAT_MAX, 26);
        for (int k = 0; k < PAT_MAX; k++)
            push_request(whsm_pkg::OP_TEXT, k == 0, pat_buf[k]);
        send_text(8, 0, 26, 1'b0);
        send_pattern(PAT_MAX + 3, 26);
        for (int k = 0; k < PAT_MAX; k++)
            push_request(whsm_pkg::OP_TEXT, k == 0, pat_buf[k]);
        drain();
        pressure_on = 1'b0;

        repeat (20) @(posedge clk);
        if (fault_count == 0 && verdict_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/whsm_pkg.sv
sv/whsm_ram.sv
sv/whsm_front.sv
sv/whsm_back.sv
sv/window_hash_string_matcher_unit.sv
sv/whsm_checker.sv
test/tb_window_hash_string_matcher_unit.sv
